FILE: rtl/lbp_rd_pkg.sv
package lbp_rd_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_MIN    = 5;

  // counter and dimension widths
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

  // configuration port
  localparam int FW_BITS     = 12;
  localparam int FH_BITS     = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  // pixels and window
  localparam int PIX_W   = 8;
  localparam int WIN     = 5;
  localparam int LINES   = WIN - 1;
  localparam int LINE_W  = LINES * PIX_W;
  localparam int CTR     = 2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;
  typedef logic [7:0] code_t;

  // ring of eight neighbours at distance one
  function automatic code_t ring_of(window_t p);
    code_t  r;
    pixel_t c;
    c    = p[CTR][CTR];
    r[0] = c < p[CTR-1][CTR-1];
    r[1] = c < p[CTR-1][CTR];
    r[2] = c < p[CTR-1][CTR+1];
    r[3] = c < p[CTR][CTR+1];
    r[4] = c < p[CTR+1][CTR+1];
    r[5] = c < p[CTR+1][CTR];
    r[6] = c < p[CTR+1][CTR-1];
    r[7] = c < p[CTR][CTR-1];
    return r;
  endfunction

  // diamond of radius two
  function automatic code_t diamond_of(window_t p);
    code_t  d;
    pixel_t c;
    c    = p[CTR][CTR];
    d[0] = c < p[CTR-1][CTR-1];
    d[1] = c < p[CTR][CTR-2];
    d[2] = c < p[CTR+1][CTR-1];
    d[3] = c < p[CTR+2][CTR];
    d[4] = c < p[CTR+1][CTR+1];
    d[5] = c < p[CTR][CTR+2];
    d[6] = c < p[CTR-1][CTR+1];
    d[7] = c < p[CTR-2][CTR];
    return d;
  endfunction

endpackage

FILE: rtl/lbp_rd_ram.sv
module lbp_rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lbp_ring_and_diamond_codes.sv
// local binary pattern coder, ring and diamond codes for each inner pixel
//
// input channel: one padded 8-bit pixel per beat in raster order
//   (in_valid / in_ready / pixel_value)
// output channel: one beat per centre pixel at least two pixels inside every
//   frame edge, carrying ring_code, diamond_code and frame_done, which marks
//   the code of the last centre of the frame
// config channel: cfg_index 0 sets frame_width, 1 sets frame_height; a write
//   also restarts the frame at row 0, column 0; other indexes are ignored;
//   cfg_ready is always high, writes belong in idle gaps only
// a result passes through the input stage register, then into the output register
// throughput: one pixel per cycle unless a result waits, set by the line store read in
//   the accept cycle and written back on its separate write port as the pixel moves on
// stall: the input stage acts as a skid, so one more pixel that makes a code is taken
//   while a result waits; after that in_ready drops until out_ready returns
// reset: counters and window cleared, width and height back to 2048, output
//   empty; line store contents stay undefined until written
module lbp_ring_and_diamond_codes
  import lbp_rd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIX_W-1:0]       pixel_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             ring_code,
  output logic [7:0]             diamond_code,
  output logic                   frame_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;

  // position of the next pixel
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // input stage, also the skid slot
  logic             s1_valid;
  pixel_t           s1_pixel;
  logic [COL_W-1:0] s1_col;
  logic             s1_emit;
  logic             s1_done;

  window_t window_pixels;
  window_t window_next;

  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;

  logic [WIDTH_W-1:0]  eff_width;
  logic [HEIGHT_W-1:0] eff_height;
  logic [COL_W-1:0]    col_eff;
  logic [ROW_W-1:0]    row_eff;
  logic [COL_W-1:0]    col_last;
  logic [ROW_W-1:0]    row_last;

  logic in_beat;
  logic s1_adv;
  logic out_free;
  logic cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT);

  // clamp the programmed dimensions into the supported range
  always_comb begin
    if (frame_width < FW_BITS'(DIM_MIN)) begin
      eff_width = WIDTH_W'(DIM_MIN);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = WIDTH_W'(frame_width);
    end
    if (frame_height < FH_BITS'(DIM_MIN)) begin
      eff_height = HEIGHT_W'(DIM_MIN);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_height = HEIGHT_W'(frame_height);
    end
  end

  assign col_last = COL_W'(eff_width - WIDTH_W'(1));
  assign row_last = ROW_W'(eff_height - HEIGHT_W'(1));

  // a position past a shrunken edge is held at the last column or row
  assign col_eff = ({1'b0, col} >= (COL_W + 1)'(eff_width)) ? col_last : col;
  assign row_eff = ({1'b0, row} >= (ROW_W + 1)'(eff_height)) ? row_last : row;

  // handshakes: the output register frees up as its beat leaves
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!s1_emit || out_free);
  assign in_ready = !s1_valid || s1_adv;
  assign in_beat  = in_valid && in_ready;

  // each word holds one column of the four rows above, oldest in the low byte
  lbp_rd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_en   (in_beat),
    .rd_addr (col_eff),
    .rd_data (line_rd)
  );

  // age the column by one row: drop the oldest, add the new pixel on top
  assign line_wr = {s1_pixel, line_rd[LINE_W-1:PIX_W]};

  // window shifts left by one column, new column enters at the right
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        window_next[k][j] = window_pixels[k][j+1];
      end
    end
    for (int k = 0; k < LINES; k++) begin
      window_next[k][WIN-1] = line_rd[k*PIX_W +: PIX_W];
    end
    window_next[WIN-1][WIN-1] = s1_pixel;
  end

  // position counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      frame_width  <= FW_BITS'(2048);
      frame_height <= FH_BITS'(2048);
    end else begin
      if (in_beat) begin
        if (col_eff == col_last) begin
          col <= '0;
          row <= (row_eff == row_last) ? '0 : row_eff + ROW_W'(1);
        end else begin
          col <= col_eff + COL_W'(1);
          row <= row_eff;
        end
      end
      // a register write restarts the frame
      if (cfg_hit) begin
        col <= '0;
        row <= '0;
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width <= cfg_data[FW_BITS-1:0];
        end else begin
          frame_height <= cfg_data[FH_BITS-1:0];
        end
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel <= pixel_value;
      s1_col   <= col_eff;
      // centre two rows up and two columns left is fully inside the frame
      s1_emit  <= (32'(row_eff) >= 32'(LINES)) && (32'(col_eff) >= 32'(LINES));
      s1_done  <= (row_eff == row_last) && (col_eff == col_last);
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_pixels <= '0;
    end else if (s1_adv) begin
      window_pixels <= window_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      ring_code    <= ring_of(window_next);
      diamond_code <= diamond_of(window_next);
      frame_done   <= s1_done;
    end
  end

endmodule

FILE: dv/lbp_code_checker.sv
`timescale 1ns / 100ps

module lbp_code_checker
  import lbp_rd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [PIX_W-1:0]       pixel_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             ring_code,
  input  logic [7:0]             diamond_code,
  input  logic                   frame_done,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     codes_seen,
  output int                     frames_seen
);

  localparam int WIDTH_AT_RESET  = 2048;
  localparam int HEIGHT_AT_RESET = 2048;

  typedef struct packed {
    code_t ring;
    code_t diamond;
    logic  last;
  } lbp_beat_t;

  // neighbour offsets (row, col) for code bits 0..7
  int ring_dr [8] = '{-1, -1, -1,  0,  1,  1,  1,  0};
  int ring_dc [8] = '{-1,  0,  1,  1,  1,  0, -1, -1};
  int diam_dr [8] = '{-1,  0,  1,  2,  1,  0, -1, -2};
  int diam_dc [8] = '{-1, -2, -1,  0,  1,  2,  1,  0};

  pixel_t      line_mem [LINES][MAX_WIDTH];
  pixel_t      win [WIN][WIN];
  int          row_pos;
  int          col_pos;
  int          width_eff;
  int          height_eff;
  lbp_beat_t   expected_codes [$];

  function automatic int dim_clamp(int v, int hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // one pixel into the line stores and the window, queue a code beat if a centre completes
  task automatic shift_in_pixel(pixel_t px);
    int        r;
    int        c;
    pixel_t    column [WIN];
    pixel_t    ctr;
    lbp_beat_t beat;
    r = row_pos;
    c = col_pos;
    if (c >= width_eff) c = width_eff - 1;
    if (r >= height_eff) r = height_eff - 1;
    for (int k = 0; k < LINES; k++) column[k] = line_mem[k][c];
    column[LINES] = px;
    for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k + 1][c];
    line_mem[LINES - 1][c] = px;
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN - 1; j++) win[k][j] = win[k][j + 1];
      win[k][WIN - 1] = column[k];
    end
    if (r >= LINES && c >= LINES) begin
      ctr = win[CTR][CTR];
      for (int i = 0; i < 8; i++) begin
        beat.ring[i]    = ctr < win[CTR + ring_dr[i]][CTR + ring_dc[i]];
        beat.diamond[i] = ctr < win[CTR + diam_dr[i]][CTR + diam_dc[i]];
      end
      beat.last = (r == height_eff - 1) && (c == width_eff - 1);
      expected_codes.push_back(beat);
    end
    if (c + 1 >= width_eff) begin
      col_pos = 0;
      row_pos = (r + 1 >= height_eff) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin : watch
    lbp_beat_t got;
    lbp_beat_t want;
    if (rst) begin
      for (int k = 0; k < LINES; k++)
        for (int j = 0; j < MAX_WIDTH; j++) line_mem[k][j] = '0;
      for (int k = 0; k < WIN; k++)
        for (int j = 0; j < WIN; j++) win[k][j] = '0;
      row_pos = 0;
      col_pos = 0;
      width_eff = WIDTH_AT_RESET;
      height_eff = HEIGHT_AT_RESET;
      expected_codes.delete();
      mismatches = 0;
      codes_seen = 0;
      frames_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {ring_code, diamond_code, frame_done};
        codes_seen++;
        if (frame_done) frames_seen++;
        if (expected_codes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected code beat: ring %02h diamond %02h last %0b",
                   $time, got.ring, got.diamond, got.last);
        end else begin
          want = expected_codes.pop_front();
          if (got !== want) begin
            mismatches++;
            $display(
              "%0t: mismatch: expected ring %02h diamond %02h last %0b, got %02h %02h %0b",
              $time, want.ring, want.diamond, want.last,
              got.ring, got.diamond, got.last);
          end
        end
      end
      if (in_valid && in_ready) shift_in_pixel(pixel_value);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_eff = dim_clamp(int'(cfg_data[FW_BITS-1:0]), MAX_WIDTH);
          row_pos = 0;
          col_pos = 0;
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_eff = dim_clamp(int'(cfg_data[FH_BITS-1:0]), MAX_HEIGHT);
          row_pos = 0;
          col_pos = 0;
        end
      end
    end
    pending = expected_codes.size();
  end

endmodule

FILE: dv/lbp_ring_and_diamond_codes_tb.sv
`timescale 1ns / 100ps

module lbp_ring_and_diamond_codes_tb;
  import lbp_rd_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int OUT_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PIX_W-1:0]       pixel_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             ring_code;
  logic [7:0]             diamond_code;
  logic                   frame_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int pending;
  int codes_seen;
  int frames_seen;

  // stimulus knobs, percent per cycle
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic long_hold = 1'b0;
  int   hold_count = 0;
  int   cycles = 0;
  int   pixels_sent = 0;

  // effective frame size as the block sees it, for whole-frame bookkeeping
  int cur_w = 2048;
  int cur_h = 2048;

  // hand-built 5x5 frame around centre 100: ties, just above, just below, 0 and 255
  pixel_t probe_frame [25] = '{
    8'd255, 8'd0,   8'd101, 8'd0,   8'd255,
    8'd0,   8'd101, 8'd100, 8'd255, 8'd0,
    8'd100, 8'd150, 8'd100, 8'd99,  8'd0,
    8'd255, 8'd100, 8'd200, 8'd0,   8'd255,
    8'd0,   8'd255, 8'd255, 8'd0,   8'd255
  };

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  lbp_ring_and_diamond_codes i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ring_code    (ring_code),
    .diamond_code (diamond_code),
    .frame_done   (frame_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  lbp_code_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ring_code    (ring_code),
    .diamond_code (diamond_code),
    .frame_done   (frame_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .codes_seen   (codes_seen),
    .frames_seen  (frames_seen)
  );

  // output side: random stalls, or a long hold-off counted here while long_hold is up
  always @(negedge clk) begin
    if (long_hold && hold_count < OUT_HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!long_hold) hold_count <= 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d code beats still expected", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int dim_in_use(int v, int hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly random, with extremes and near-ties to hit the strict less-than
  function automatic pixel_t rand_pixel();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'hFF : 8'h00;
      1:       return pixel_t'($urandom_range(126, 130));
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // one pixel beat; valid stays up with the same pixel until accepted
  task automatic send_pixel(pixel_t v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // stop the input and wait until every expected code beat is out,
  // then let pixels that make no code drain out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // single register write beat, only called once the block is settled
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cur_w = dim_in_use(int'(data[FW_BITS-1:0]), MAX_WIDTH);
    if (idx == REG_FRAME_HEIGHT) cur_h = dim_in_use(int'(data[FH_BITS-1:0]), MAX_HEIGHT);
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_INDEX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, (1 << CFG_INDEX_W) - 1)),
              CFG_DATA_W'($urandom));
  endtask

  task automatic send_random_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // small frames with random sizes, partial frames, mid-frame pauses and ignored writes
  task automatic random_phase(int idle_pct, int stall_pct, int beats);
    int first;
    int total;
    int mode;
    int w_raw;
    int h_raw;
    settle();
    src_idle_pct = idle_pct;
    sink_stall_pct <= stall_pct;
    first = pixels_sent;
    while (pixels_sent - first < beats) begin
      settle();
      mode = $urandom_range(3);
      // out-of-range small sizes now and then, they count as the minimum
      w_raw = ($urandom_range(7) == 0) ? $urandom_range(DIM_MIN - 1) : $urandom_range(5, 9);
      h_raw = ($urandom_range(7) == 0) ? $urandom_range(DIM_MIN - 1) : $urandom_range(5, 8);
      if (mode != 1)
        write_reg(REG_FRAME_WIDTH, {1'($urandom_range(1)), FW_BITS'(w_raw)});
      if (mode != 0)
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
      total = cur_w * cur_h * $urandom_range(1, 2);
      // cut a frame short, the next write restarts it
      if ($urandom_range(4) == 0) total = $urandom_range(1, cur_w * cur_h - 1);
      for (int i = 0; i < total; i++) begin
        send_pixel(rand_pixel());
        // sender pause until all codes are out, sometimes with a write that must not restart
        if ($urandom_range(59) == 0) begin
          settle();
          if ($urandom_range(1)) write_unused_reg();
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // width left at its reset value of 2048, height set to the minimum:
    // a few beats into a wide frame, too early for any code
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(DIM_MIN));
    send_random_pixels(20);

    // hand-built minimum frame, one code beat with every bit case
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(DIM_MIN));
    for (int i = 0; i < 25; i++) send_pixel(probe_frame[i]);

    // all-ones width clamps to the widest line, a short start of a row
    settle();
    write_reg(REG_FRAME_WIDTH, 13'h0FFF);
    send_random_pixels(20);

    // width zero with the unused top bit set counts as the minimum,
    // all-ones height clamps to the tallest frame: rows past five keep coding
    settle();
    write_reg(REG_FRAME_WIDTH, 13'h1000);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_random_pixels(55);

    // long output hold while the sender keeps offering, so the input backs up
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(8));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(8));
    send_random_pixels(32);
    long_hold <= 1'b1;
    send_random_pixels(32);
    settle();
    long_hold <= 1'b0;

    // random frames under four flow-control phases
    random_phase(0, 0, 90);
    random_phase(50, 0, 90);
    random_phase(0, 50, 90);
    random_phase(20, 20, 90);

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d pixel beats and %0d code beats over %0d frame ends,", pixels_sent,
             codes_seen, frames_seen);
    $display("small frames, clamped sizes, partial wide and tall frames, restarts, four idle mixes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
